### sv/in_order_read_return_buffer_macros.svh
// Assertion macros shared by the in-order read return buffer.
`ifndef IN_ORDER_READ_RETURN_BUFFER_MACROS_SVH
`define IN_ORDER_READ_RETURN_BUFFER_MACROS_SVH

// Checks in the same cycle: the consequent must hold whenever the antecedent holds.
`define RIRB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Delayed check: the consequent must hold in the cycle after the antecedent.
`define RIRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/rirb_pkg.sv
// Types, constants and codes for the in-order read return buffer.
`timescale 1ns / 1ps
package rirb_pkg;

	localparam int DEPTH       = 16;
	localparam int MERGE_SLOTS = 16;
	localparam int STAMP_W     = 32;
	localparam int ADDR_W      = 40;

	localparam int IN_TDATA_W  = 80;
	localparam int IN_TUSER_W  = 4;
	localparam int OUT_TDATA_W = 80;
	localparam int OUT_TUSER_W = 2;

	localparam logic [1:0] CMD_SEND = 2'd0;
	localparam logic [1:0] CMD_CMPL = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [1:0] KIND_READ = 2'd0;

	localparam logic [1:0] RES_SEND = 2'd0;
	localparam logic [1:0] RES_CMPL = 2'd1;
	localparam logic [1:0] RES_REL  = 2'd2;
	localparam logic [1:0] RES_NONE = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_TICK = 2'b10
	} state_t;

	typedef struct packed {
		logic               valid;
		logic [STAMP_W-1:0] stamp;
		logic [ADDR_W-1:0]  addr;
		logic               notify;
	} order_entry_t;

	typedef struct packed {
		logic               push;
		logic               pop;
		logic [STAMP_W-1:0] stamp;
		logic [ADDR_W-1:0]  addr;
		logic               notify;
	} order_ctl_t;

	typedef struct packed {
		logic               valid;
		logic [STAMP_W-1:0] stamp;
	} merge_entry_t;

	typedef struct packed {
		logic               ins;
		logic               pop;
		logic [STAMP_W-1:0] stamp;
	} merge_ctl_t;

endpackage

### sv/in_order_read_return_buffer.sv
// Top level of the in-order read return buffer: request decode, release sequencer, output register.
`timescale 1ns / 1ps
// A send request answers whether it was accepted; accepted reads join an order queue of DEPTH
// cells. A completion is inserted in sorted position into a chain of sixteen merge cells, so
// the smallest stamp always sits in the first cell; a full chain drops it and flags overflow.
// A tick is first taken in and then releases results one at a time, each step waiting while a
// result is held in the output register: each step compares the two head cells, and on a match
// releases the read and shifts both chains by one. The tick ends after a read with a callback,
// or when the next pair does not match, and answers "nothing released" if no read was released.
// Input requests are not taken while a tick is releasing, nor while a result waits in the
// output register and is not being read in the same cycle. Command 3 is taken and ignored.
module in_order_read_return_buffer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// arrive_stamp, address, has_callback, controller_accepted, zero padding
	input  logic [rirb_pkg::IN_TDATA_W-1:0]   s_tdata,
	// cmd, req_kind
	input  logic [rirb_pkg::IN_TUSER_W-1:0]   s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// accepted, released_stamp, released_address, released_notify, merge_overflow, zero padding
	output logic [rirb_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// result_kind
	output logic [rirb_pkg::OUT_TUSER_W-1:0]  m_tuser,
	output logic                              m_tlast
);
	import rirb_pkg::*;

	`include "in_order_read_return_buffer_macros.svh"

	state_t state_q, state_d;

	logic [1:0]         in_cmd;
	logic [1:0]         in_kind;
	logic [STAMP_W-1:0] in_stamp;
	logic [ADDR_W-1:0]  in_addr;
	logic               in_cb;
	logic               in_ctl;
	logic               in_fire;
	logic               out_free;
	logic               tick_step;
	logic               release_now;
	logic               head_match;
	logic               next_match;
	logic               order_full;
	logic               merge_full;

	order_entry_t o_entry [DEPTH];
	merge_entry_t m_entry [MERGE_SLOTS];
	logic         m_keep  [MERGE_SLOTS];
	order_ctl_t   o_ctl;
	merge_ctl_t   m_ctl;

	logic [DEPTH-1:0]       o_valid;
	logic [DEPTH-1:0]       o_valid_inc;
	logic [MERGE_SLOTS-1:0] m_valid;
	logic [MERGE_SLOTS-1:0] m_valid_inc;

	logic               out_valid_q;
	logic [1:0]         out_kind_q;
	logic               out_acc_q;
	logic [STAMP_W-1:0] out_stamp_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic               out_notify_q;
	logic               out_ovf_q;
	logic               out_last_q;

	logic               load;
	logic [1:0]         nx_kind;
	logic               nx_acc;
	logic [STAMP_W-1:0] nx_stamp;
	logic [ADDR_W-1:0]  nx_addr;
	logic               nx_notify;
	logic               nx_ovf;
	logic               nx_last;

	assign in_cmd   = s_tuser[1:0];
	assign in_kind  = s_tuser[3:2];
	assign in_stamp = s_tdata[STAMP_W-1:0];
	assign in_addr  = s_tdata[STAMP_W+ADDR_W-1:STAMP_W];
	assign in_cb    = s_tdata[STAMP_W+ADDR_W];
	assign in_ctl   = s_tdata[STAMP_W+ADDR_W+1];

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign in_fire   = s_tvalid && s_tready;
	assign tick_step = (state_q == ST_TICK) && out_free;

	assign order_full = o_entry[DEPTH-1].valid;
	assign merge_full = m_entry[MERGE_SLOTS-1].valid;

	assign head_match = o_entry[0].valid && m_entry[0].valid
		&& (o_entry[0].stamp == m_entry[0].stamp);
	// The pair that becomes the head after this release decides whether the tick goes on.
	assign next_match = o_entry[1].valid && m_entry[1].valid
		&& (o_entry[1].stamp == m_entry[1].stamp);
	assign release_now = tick_step && head_match;

	assign o_ctl = '{
		push:   in_fire && (in_cmd == CMD_SEND) && !order_full && in_ctl
			&& (in_kind == KIND_READ),
		pop:    release_now,
		stamp:  in_stamp,
		addr:   in_addr,
		notify: in_cb
	};

	assign m_ctl = '{
		ins:   in_fire && (in_cmd == CMD_CMPL) && !merge_full,
		pop:   release_now,
		stamp: in_stamp
	};

	for (genvar i = 0; i < DEPTH; i++) begin : g_order
		order_entry_t nxt;
		logic         prv;
		if (i == DEPTH - 1) begin : g_tail
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = o_entry[i+1];
		end
		if (i == 0) begin : g_head
			assign prv = 1'b1;
		end else begin : g_rest
			assign prv = o_entry[i-1].valid;
		end
		rirb_order_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (o_ctl),
			.prev_valid (prv),
			.next_entry (nxt),
			.entry      (o_entry[i])
		);
		assign o_valid[i] = o_entry[i].valid;
	end

	for (genvar i = 0; i < MERGE_SLOTS; i++) begin : g_merge
		merge_entry_t nxt;
		merge_entry_t prv;
		logic         prv_keep;
		if (i == MERGE_SLOTS - 1) begin : g_tail
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = m_entry[i+1];
		end
		if (i == 0) begin : g_head
			assign prv      = '0;
			assign prv_keep = 1'b1;
		end else begin : g_rest
			assign prv      = m_entry[i-1];
			assign prv_keep = m_keep[i-1];
		end
		rirb_merge_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (m_ctl),
			.prev_entry (prv),
			.prev_keep  (prv_keep),
			.next_entry (nxt),
			.entry      (m_entry[i]),
			.keep       (m_keep[i])
		);
		assign m_valid[i] = m_entry[i].valid;
	end

	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		nx_kind   = RES_NONE;
		nx_acc    = 1'b0;
		nx_stamp  = '0;
		nx_addr   = '0;
		nx_notify = 1'b0;
		nx_ovf    = 1'b0;
		nx_last   = 1'b1;
		if (in_fire) begin
			unique case (in_cmd)
				CMD_SEND: begin
					load    = 1'b1;
					nx_kind = RES_SEND;
					nx_acc  = !order_full && in_ctl;
				end
				CMD_CMPL: begin
					load    = 1'b1;
					nx_kind = RES_CMPL;
					nx_ovf  = merge_full;
				end
				CMD_TICK: begin
					state_d = ST_TICK;
				end
				CMD_NONE: begin
					state_d = ST_IDLE;
				end
			endcase
		end else if (tick_step) begin
			load = 1'b1;
			if (head_match) begin
				nx_kind   = RES_REL;
				nx_stamp  = o_entry[0].stamp;
				nx_addr   = o_entry[0].addr;
				nx_notify = o_entry[0].notify;
				nx_last   = o_entry[0].notify || !next_match;
			end
			if (nx_last) begin
				state_d = ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q   <= nx_kind;
			out_acc_q    <= nx_acc;
			out_stamp_q  <= nx_stamp;
			out_addr_q   <= nx_addr;
			out_notify_q <= nx_notify;
			out_ovf_q    <= nx_ovf;
			out_last_q   <= nx_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(OUT_TDATA_W - STAMP_W - ADDR_W - 3)'(0),
		out_ovf_q, out_notify_q, out_addr_q, out_stamp_q, out_acc_q};

	assign o_valid_inc = o_valid + 1'b1;
	assign m_valid_inc = m_valid + 1'b1;

	`RIRB_ASSERT_NOW(a_order_packed, 1'b1, (o_valid & o_valid_inc) == '0, "order chain has a gap")
	`RIRB_ASSERT_NOW(a_merge_packed, 1'b1, (m_valid & m_valid_inc) == '0, "merge chain has a gap")
	`RIRB_ASSERT_NEXT(a_tick_enter, in_fire && (in_cmd == CMD_TICK), state_q == ST_TICK, "tick lost")
	`RIRB_ASSERT_NOW(a_none_last, m_tvalid && (m_tuser == RES_NONE), m_tlast, "empty tick not last")

endmodule

### sv/rirb_order_cell.sv
// One cell of the order queue chain: holds one outstanding read, shifts towards the head.
`timescale 1ns / 1ps
module rirb_order_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rirb_pkg::order_ctl_t   ctl,
	input  logic                  prev_valid,
	input  rirb_pkg::order_entry_t next_entry,
	output rirb_pkg::order_entry_t entry
);
	import rirb_pkg::*;

	logic               valid_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               notify_q;
	logic               take_push;

	// The first empty cell behind a full one is the tail of the queue.
	assign take_push = ctl.push && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= next_entry.valid;
		end else if (take_push) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			stamp_q  <= next_entry.stamp;
			addr_q   <= next_entry.addr;
			notify_q <= next_entry.notify;
		end else if (take_push) begin
			stamp_q  <= ctl.stamp;
			addr_q   <= ctl.addr;
			notify_q <= ctl.notify;
		end
	end

	assign entry = '{valid: valid_q, stamp: stamp_q, addr: addr_q, notify: notify_q};

endmodule

### sv/rirb_merge_cell.sv
// One cell of the sorted merge chain: completions are kept in rising stamp order.
`timescale 1ns / 1ps
module rirb_merge_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rirb_pkg::merge_ctl_t   ctl,
	input  rirb_pkg::merge_entry_t prev_entry,
	input  logic                  prev_keep,
	input  rirb_pkg::merge_entry_t next_entry,
	output rirb_pkg::merge_entry_t entry,
	output logic                  keep
);
	import rirb_pkg::*;

	logic               valid_q;
	logic [STAMP_W-1:0] stamp_q;

	// A cell keeps its stamp when it is no larger than the new one, so equal stamps stay in
	// arrival order. The first cell that does not keep takes the new stamp, the rest shift up.
	assign keep = valid_q && (stamp_q <= ctl.stamp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= next_entry.valid;
		end else if (ctl.ins && !keep) begin
			valid_q <= prev_keep ? 1'b1 : prev_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			stamp_q <= next_entry.stamp;
		end else if (ctl.ins && !keep) begin
			stamp_q <= prev_keep ? ctl.stamp : prev_entry.stamp;
		end
	end

	assign entry = '{valid: valid_q, stamp: stamp_q};

endmodule
